### rtl/scsa_pkg.sv
// Package for the size-class slab allocator: field structs, status codes,
// state machine type and geometry constants. No dependencies.
`default_nettype none
package scsa_pkg;

  localparam int MinClassLog2  = 5;
  localparam int MaxClassLog2  = 11;
  localparam int SlabBytesLog2 = 12;
  localparam int SlabFrames    = 16;
  localparam int ClassCount    = MaxClassLog2 - MinClassLog2 + 1;
  localparam int SlotW         = SlabBytesLog2 - MinClassLog2;
  localparam int FrameW        = $clog2(SlabFrames);
  localparam int ClassW        = $clog2(ClassCount);

  typedef logic [FrameW-1:0] frame_t;
  typedef logic [ClassW-1:0] class_t;
  typedef logic [SlotW:0]    slot_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_TOO_LARGE = 2'd1,
    ST_EXHAUSTED = 2'd2,
    ST_BAD_ADDR  = 2'd3
  } status_t;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  typedef struct packed {
    logic        mode;
    logic [11:0] request_size;
    logic [15:0] free_address;
  } in_item_t;

  typedef struct packed {
    logic [15:0] slot_address;
    logic [1:0]  status;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_EVAL,
    S_LINK,
    S_DONE
  } fsm_t;

endpackage
`default_nettype wire

### rtl/size_class_slab_allocator.sv
// Size-class slab allocator top level: request decode, frame chain walk and
// freed-slot link memory. Depends on scsa_pkg.
//
// One transaction in, one transaction out; requests are handled one at a time.
// A free or a too-large allocate passes through the read and done states. An
// allocate passes through the read state, then the evaluate state once per frame
// of its class chain that it visits (frame state check) and once more when a
// full chain makes it take a fresh pool frame, then the link state for the
// freed-slot link memory read when it pops a recycled slot, then the done state.
// A new request is accepted once the previous result has been taken, or in the
// cycle that it is taken.
`default_nettype none
module size_class_slab_allocator import scsa_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_data
);

  localparam int LinkDepth = SlabFrames << SlotW;
  localparam int LinkAw    = FrameW + SlotW;

  // per-frame and per-class state (small, fixed indexing -> flops)
  frame_t  head_r   [ClassCount];
  logic    headv_r  [ClassCount];
  frame_t  older_r  [SlabFrames];
  logic    olderv_r [SlabFrames];
  class_t  fcls_r   [SlabFrames];
  logic    inuse_r  [SlabFrames];
  slot_t   never_r  [SlabFrames];
  slot_t   fhead_r  [SlabFrames];
  logic [FrameW:0] next_free_r;

  // freed slot links: synchronous memory
  logic [SlotW-1:0] link_mem [LinkDepth];
  logic [SlotW-1:0] link_q;
  logic             link_we;
  logic [LinkAw-1:0] link_wa, link_ra;
  logic [SlotW-1:0] link_wd;

  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[link_wa] <= link_wd;
    end
    link_q <= link_mem[link_ra];
  end

  fsm_t state_r, state_nxt;
  in_item_t req_r;
  class_t  cls_r;
  frame_t  cur_r, cur_nxt;
  logic    have_r, have_nxt;
  out_item_t res_r;
  logic out_valid_r;

  // request decode
  logic [3:0] lg;
  logic       too_large;
  always_comb begin
    lg = 4'(MinClassLog2);
    for (int i = MaxClassLog2; i > MinClassLog2; i--) begin
      if (req_r.request_size > 12'((1 << (i - 1)))) begin
        lg = 4'(i);
        break;
      end
    end
  end
  assign too_large = req_r.request_size > 12'(1 << MaxClassLog2);

  // current frame view
  slot_t  slot_cnt;
  logic   room;
  frame_t ff;
  logic [SlabBytesLog2-1:0] off;
  slot_t  fslot;
  logic   addr_frame_ok;
  always_comb begin
    slot_cnt = slot_t'(1) << (SlotW - int'(fcls_r[cur_r]));
    room     = (fhead_r[cur_r] != '0) || (never_r[cur_r] < slot_cnt);
    ff       = req_r.free_address[SlabBytesLog2 +: FrameW];
    off      = req_r.free_address[SlabBytesLog2-1:0];
    fslot    = slot_t'(off >> (MinClassLog2 + int'(fcls_r[ff])));
    addr_frame_ok = ((req_r.free_address >> SlabBytesLog2) < 16'(SlabFrames)) &&
                    inuse_r[ff];
  end

  function automatic logic [15:0] mk_addr(frame_t f, class_t c, slot_t s);
    logic [15:0] a;
    a = 16'(f) << SlabBytesLog2;
    a = a | (16'(s) << (MinClassLog2 + int'(c)));
    return a;
  endfunction

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_valid && !in_stall) state_nxt = S_READ;
      S_READ: begin
        if (req_r.mode == MODE_FREE || too_large) state_nxt = S_DONE;
        else state_nxt = S_EVAL;
      end
      S_EVAL: begin
        if (!have_r || room) begin
          if (have_r && room && fhead_r[cur_r] != '0) state_nxt = S_LINK;
          else state_nxt = S_DONE;
        end else begin
          state_nxt = S_EVAL;
        end
      end
      S_LINK: state_nxt = S_DONE;
      S_DONE: if (!out_valid_r || !out_stall) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // chain walk next values
  always_comb begin
    cur_nxt  = cur_r;
    have_nxt = have_r;
    if (state_r == S_READ) begin
      cur_nxt  = head_r[class_t'(lg - 4'(MinClassLog2))];
      have_nxt = headv_r[class_t'(lg - 4'(MinClassLog2))];
    end else if (state_r == S_EVAL && have_r && !room) begin
      cur_nxt  = older_r[cur_r];
      have_nxt = olderv_r[cur_r];
    end
  end

  // memory port control
  always_comb begin
    link_ra = {cur_r, fhead_r[cur_r][SlotW-1:0]};
    link_we = (state_r == S_READ) && req_r.mode == MODE_FREE && addr_frame_ok &&
              fslot != '0 && fslot < never_r[ff];
    link_wa = {ff, fslot[SlotW-1:0]};
    link_wd = fhead_r[ff][SlotW-1:0];
  end

  // a waiting result holds off the next request
  assign in_stall  = (state_r != S_IDLE) || (out_valid_r && out_stall);
  assign out_valid = out_valid_r;
  assign out_data  = res_r;

  // state and bookkeeping registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      next_free_r <= (FrameW+1)'(ClassCount);
      for (int k = 0; k < ClassCount; k++) begin
        head_r[k]  <= frame_t'(k);
        headv_r[k] <= 1'b1;
      end
      for (int k = 0; k < SlabFrames; k++) begin
        olderv_r[k] <= 1'b0;
        older_r[k]  <= '0;
        fcls_r[k]   <= (k < ClassCount) ? class_t'(k) : '0;
        inuse_r[k]  <= k < ClassCount;
        never_r[k]  <= slot_t'(1);
        fhead_r[k]  <= '0;
      end
    end else begin
      state_r <= state_nxt;
      cur_r   <= cur_nxt;
      have_r  <= have_nxt;
      if (state_r == S_DONE) out_valid_r <= 1'b1;
      else if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_valid && !in_stall) req_r <= in_data;
        end
        S_READ: begin
          cls_r  <= class_t'(lg - 4'(MinClassLog2));
          if (req_r.mode == MODE_FREE) begin
            if (link_we) fhead_r[ff] <= fslot;
            res_r <= '{slot_address: '0, status: link_we ? ST_OK : ST_BAD_ADDR};
          end else begin
            res_r <= '{slot_address: '0, status: too_large ? ST_TOO_LARGE : ST_OK};
          end
        end
        S_EVAL: begin
          if (have_r && room) begin
            res_r.slot_address <= mk_addr(cur_r, fcls_r[cur_r],
              (fhead_r[cur_r] != '0) ? fhead_r[cur_r] : never_r[cur_r]);
            if (fhead_r[cur_r] == '0) never_r[cur_r] <= never_r[cur_r] + 1'b1;
          end else if (!have_r) begin
            if (next_free_r >= (FrameW+1)'(SlabFrames)) begin
              res_r.status <= ST_EXHAUSTED;
            end else begin
              fcls_r[next_free_r[FrameW-1:0]]   <= cls_r;
              inuse_r[next_free_r[FrameW-1:0]]  <= 1'b1;
              never_r[next_free_r[FrameW-1:0]]  <= slot_t'(2);
              fhead_r[next_free_r[FrameW-1:0]]  <= '0;
              older_r[next_free_r[FrameW-1:0]]  <= head_r[cls_r];
              olderv_r[next_free_r[FrameW-1:0]] <= headv_r[cls_r];
              head_r[cls_r]  <= next_free_r[FrameW-1:0];
              headv_r[cls_r] <= 1'b1;
              next_free_r    <= next_free_r + 1'b1;
              res_r.slot_address <= mk_addr(next_free_r[FrameW-1:0], cls_r, slot_t'(1));
            end
          end
        end
        S_LINK: begin
          // pop the recycled slot: link memory data now valid
          fhead_r[cur_r] <= {1'b0, link_q};
        end
        default: ;
      endcase
    end
  end

  // checks
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid) else $error("result dropped");
  a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EVAL |-> in_stall) else $error("accept while busy");
  a_pool_bound: assert property (@(posedge clk) disable iff (!rst_n)
    next_free_r <= (FrameW+1)'(SlabFrames)) else $error("pool overrun");
  a_err_addr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_OK |-> out_data.slot_address == '0)
    else $error("address on error");

endmodule
`default_nettype wire
